>>> rtl/core/hvd_pkg.sv
`default_nettype none

package hvd_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 20;
    localparam int CORDIC_STEPS_DEF    = 24;

    // CORDIC datapath width: Q30 with headroom for gain growth and sign
    localparam int CW = 34;
    // Q30 magnitude in [0, 1]
    localparam int QW = 31;

    localparam int RADIUS_W = 29;
    localparam int DIST_W   = 31;
    localparam int D2R_W    = 27;

    typedef logic signed [CW-1:0] t_cw;
    typedef logic [QW-1:0]        t_q30;

    localparam t_q30 ONE_Q30  = QW'(1) << 30;
    localparam t_cw  ONE_CW   = CW'(1) <<< 30;
    localparam t_cw  CORDIC_GAIN = CW'(652032874);

    localparam logic [RADIUS_W-1:0] RADIUS_RESET   = RADIUS_W'(259516006);
    localparam logic [DIST_W-1:0]   DIST_MAX       = {DIST_W{1'b1}};
    localparam logic [D2R_W-1:0]    DEG_TO_RAD_Q32 = D2R_W'(74961321);

    // floor(atan(2^-k) * 2^30)
    function automatic logic [31:0] atan_q30(input logic [4:0] k);
        logic [31:0] v;
        unique case (k)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000007;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000000;
            5'd31: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/hvd_cordic_rot.sv
`default_nettype none

module hvd_cordic_rot import hvd_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_cw  i_angle,
    output logic      o_valid,
    output t_cw       o_cos,
    output t_cw       o_sin
);

    t_cw  r_x [STEPS];
    t_cw  r_y [STEPS];
    t_cw  r_z [STEPS];
    logic r_v [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam t_cw ATAN = CW'(atan_q30(5'(i)));
        t_cw  x_in, y_in, z_in;
        logic v_in;

        if (i == 0) begin : g_first
            assign x_in = CORDIC_GAIN;
            assign y_in = '0;
            assign z_in = i_angle;
            assign v_in = i_valid;
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
            assign v_in = r_v[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_en) begin
                r_v[i] <= v_in;
            end
        end

        // rotate towards zero residual angle
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (z_in >= 0) begin
                    r_x[i] <= x_in - (y_in >>> i);
                    r_y[i] <= y_in + (x_in >>> i);
                    r_z[i] <= z_in - ATAN;
                end else begin
                    r_x[i] <= x_in + (y_in >>> i);
                    r_y[i] <= y_in - (x_in >>> i);
                    r_z[i] <= z_in + ATAN;
                end
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_cos   = r_x[STEPS-1];
    assign o_sin   = r_y[STEPS-1];

endmodule

`default_nettype wire

>>> rtl/core/hvd_isqrt.sv
`default_nettype none

module hvd_isqrt import hvd_pkg::*; #(
    parameter int RW = QW
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [2*RW-1:0] i_rad,
    output logic                 o_valid,
    output logic [RW-1:0]        o_root
);

    localparam int REM_W = RW + 3;

    logic [RW-1:0]    r_root [RW];
    logic             r_v    [RW];
    logic [REM_W-1:0] r_rem  [RW-1];
    logic [2*RW-1:0]  r_rad  [RW-1];

    // one result bit per stage, restoring digit recurrence
    for (genvar i = 0; i < RW; i++) begin : g_step
        logic [REM_W-1:0] rem_in, rem_sh, trial;
        logic [RW-1:0]    root_in;
        logic [2*RW-1:0]  rad_in;
        logic             v_in, ge;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign v_in    = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[i-1];
            assign root_in = r_root[i-1];
            assign rad_in  = r_rad[i-1];
            assign v_in    = r_v[i-1];
        end

        assign rem_sh = {rem_in[RW:0], rad_in[2*RW-1 -: 2]};
        assign trial  = REM_W'({root_in, 2'b01});
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_en) begin
                r_v[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[i] <= {root_in[RW-2:0], ge};
            end
        end

        if (i < RW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[i] <= ge ? (rem_sh - trial) : rem_sh;
                    r_rad[i] <= {rad_in[2*RW-3:0], 2'b00};
                end
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];

endmodule

`default_nettype wire

>>> rtl/core/hvd_cordic_vec.sv
`default_nettype none

module hvd_cordic_vec import hvd_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_cw  i_x,
    input  wire t_cw  i_y,
    output logic      o_valid,
    output t_cw       o_angle
);

    t_cw  r_x [STEPS];
    t_cw  r_y [STEPS];
    t_cw  r_z [STEPS];
    logic r_v [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam t_cw ATAN = CW'(atan_q30(5'(i)));
        t_cw  x_in, y_in, z_in;
        logic v_in;

        if (i == 0) begin : g_first
            assign x_in = i_x;
            assign y_in = i_y;
            assign z_in = '0;
            assign v_in = i_valid;
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
            assign v_in = r_v[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_en) begin
                r_v[i] <= v_in;
            end
        end

        // drive y towards zero, accumulate the angle
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (y_in >= 0) begin
                    r_x[i] <= x_in + (y_in >>> i);
                    r_y[i] <= y_in - (x_in >>> i);
                    r_z[i] <= z_in + ATAN;
                end else begin
                    r_x[i] <= x_in - (y_in >>> i);
                    r_y[i] <= y_in + (x_in >>> i);
                    r_z[i] <= z_in - ATAN;
                end
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_angle = r_z[STEPS-1];

endmodule

`default_nettype wire

>>> rtl/core/haversine_distance.sv
// Throughput: one transaction per cycle while i_stall does not hold the output;
// every stage is a register, nothing iterates.
// Depth is set by the two CORDIC pipes (one stage per step) and the 31-stage square root.
// Reset (i_rst_n low, synchronous): clears all valid bits, radius returns to 3959.9 miles.
// The whole pipe holds while a result waits and i_stall is high.
`default_nettype none

module haversine_distance import hvd_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input channel
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic signed [27:0]        i_first_lat,
    input  wire logic signed [28:0]        i_first_lon,
    input  wire logic signed [27:0]        i_second_lat,
    input  wire logic signed [28:0]        i_second_lon,
    // output channel
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [DIST_W-1:0]              o_distance,
    // configuration port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int F  = ANGLE_FRAC_BITS;
    // signed width for degree differences: holds +-720 degrees and any raw difference
    localparam int DW = (F + 11 > 30) ? F + 11 : 30;
    // magnitude width: up to 180 degrees
    localparam int MW = F + 8;
    localparam int PW = MW + D2R_W;

    localparam logic REG_IDX_RADIUS = 1'b0;

    localparam logic signed [DW-1:0] DEG90  = DW'(90)  <<< F;
    localparam logic signed [DW-1:0] DEG180 = DW'(180) <<< F;
    localparam logic signed [DW-1:0] DEG360 = DW'(360) <<< F;
    localparam logic signed [DW-1:0] DEG540 = DW'(540) <<< F;
    localparam logic signed [DW-1:0] DEG720 = DW'(720) <<< F;

    // global advance: every stage moves unless the output register is held
    logic adv;
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    //------------------------------------------------------------------
    // Configuration: sphere radius, Q16 miles
    //------------------------------------------------------------------
    logic [RADIUS_W-1:0] r_radius;
    logic                cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_RADIUS) ? 32'(r_radius) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (cfg_wr && paddr[2] == REG_IDX_RADIUS) begin
            r_radius <= pwdata[RADIUS_W-1:0];
        end
    end

    //------------------------------------------------------------------
    // Stage A: clamp latitudes to +-90 degrees, raw longitude difference
    //------------------------------------------------------------------
    logic                  r_a_valid;
    logic signed [DW-1:0]  r_a_lat1, r_a_lat2, r_a_dlon;
    logic signed [DW-1:0]  lat1_x, lat2_x;

    assign lat1_x = DW'(i_first_lat);
    assign lat2_x = DW'(i_second_lat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_lat1 <= (lat1_x > DEG90) ? DEG90 : ((lat1_x < -DEG90) ? -DEG90 : lat1_x);
            r_a_lat2 <= (lat2_x > DEG90) ? DEG90 : ((lat2_x < -DEG90) ? -DEG90 : lat2_x);
            r_a_dlon <= DW'(i_second_lon) - DW'(i_first_lon);
        end
    end

    //------------------------------------------------------------------
    // Stage B: latitude difference, longitude difference wrapped into [-180, 180)
    //------------------------------------------------------------------
    logic                  r_b_valid;
    logic signed [DW-1:0]  r_b_ang [4];
    logic signed [DW-1:0]  dlon_wrap;

    always_comb begin
        priority if (r_a_dlon >= DEG540) begin
            dlon_wrap = r_a_dlon - DEG720;
        end else if (r_a_dlon >= DEG180) begin
            dlon_wrap = r_a_dlon - DEG360;
        end else if (r_a_dlon < -DEG540) begin
            dlon_wrap = r_a_dlon + DEG720;
        end else if (r_a_dlon < -DEG180) begin
            dlon_wrap = r_a_dlon + DEG360;
        end else begin
            dlon_wrap = r_a_dlon;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    // lanes: latitude difference, longitude difference, lat1, lat2
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_ang[0] <= r_a_lat2 - r_a_lat1;
            r_b_ang[1] <= dlon_wrap;
            r_b_ang[2] <= r_a_lat1;
            r_b_ang[3] <= r_a_lat2;
        end
    end

    //------------------------------------------------------------------
    // Stages C-E: degrees to Q30 radians, round half up on the magnitude
    //------------------------------------------------------------------
    logic            r_c_valid, r_d_valid, r_e_valid;
    logic [MW-1:0]   r_c_mag [4];
    logic            r_c_neg [4];
    logic [PW-1:0]   r_d_prod [4];
    logic            r_d_neg [4];
    t_cw             r_e_ang [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (adv) begin
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_lane
        // half angles divide by a further two
        localparam int SH = (j < 2) ? F + 3 : F + 2;
        logic [PW:0] rnd;
        logic [31:0] rad;

        assign rnd = (PW+1)'(r_d_prod[j]) + ((PW+1)'(1) << (SH - 1));
        assign rad = 32'(rnd >> SH);

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_c_neg[j]  <= r_b_ang[j] < 0;
                r_c_mag[j]  <= MW'((r_b_ang[j] < 0) ? -r_b_ang[j] : r_b_ang[j]);
                r_d_prod[j] <= PW'(r_c_mag[j]) * PW'(DEG_TO_RAD_Q32);
                r_d_neg[j]  <= r_c_neg[j];
                r_e_ang[j]  <= r_d_neg[j] ? -CW'(rad) : CW'(rad);
            end
        end
    end

    //------------------------------------------------------------------
    // Rotation CORDIC on all four angles in parallel
    //------------------------------------------------------------------
    logic rot_valid;
    t_cw  rot_cos [4];
    t_cw  rot_sin [4];

    hvd_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_dlat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(r_e_valid),
        .i_angle(r_e_ang[0]), .o_valid(rot_valid), .o_cos(rot_cos[0]), .o_sin(rot_sin[0])
    );
    hvd_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_dlon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(r_e_valid),
        .i_angle(r_e_ang[1]), .o_valid(), .o_cos(rot_cos[1]), .o_sin(rot_sin[1])
    );
    hvd_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_lat1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(r_e_valid),
        .i_angle(r_e_ang[2]), .o_valid(), .o_cos(rot_cos[2]), .o_sin(rot_sin[2])
    );
    hvd_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_lat2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(r_e_valid),
        .i_angle(r_e_ang[3]), .o_valid(), .o_cos(rot_cos[3]), .o_sin(rot_sin[3])
    );

    //------------------------------------------------------------------
    // Stages F-J: clamp, square, combine into the haversine term h
    //------------------------------------------------------------------
    logic           r_f_valid, r_g_valid, r_h_valid, r_i_valid, r_j_valid;
    t_q30           r_f_sa, r_f_sb, r_f_c1, r_f_c2;
    logic [2*QW-1:0] r_g_pa, r_g_pb, r_g_pc;
    t_q30           r_h_a, r_h_b, r_h_cc;
    logic [2*QW-1:0] r_i_prod;
    t_q30           r_i_a;
    t_q30           r_j_h;
    t_cw            sa_mag, sb_mag;
    logic [31:0]    h_sum;

    localparam logic [2*QW-1:0] HALF_Q30 = (2*QW)'(1) << 29;

    assign sa_mag = (rot_sin[0] < 0) ? -rot_sin[0] : rot_sin[0];
    assign sb_mag = (rot_sin[1] < 0) ? -rot_sin[1] : rot_sin[1];
    assign h_sum  = 32'(r_i_a) + 32'((r_i_prod + HALF_Q30) >> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_i_valid <= 1'b0;
            r_j_valid <= 1'b0;
        end else if (adv) begin
            r_f_valid <= rot_valid;
            r_g_valid <= r_f_valid;
            r_h_valid <= r_g_valid;
            r_i_valid <= r_h_valid;
            r_j_valid <= r_i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // sine magnitudes at most one, cosines within [0, 1]
            r_f_sa <= (sa_mag > ONE_CW) ? ONE_Q30 : QW'(sa_mag);
            r_f_sb <= (sb_mag > ONE_CW) ? ONE_Q30 : QW'(sb_mag);
            r_f_c1 <= (rot_cos[2] < 0) ? '0 :
                      ((rot_cos[2] > ONE_CW) ? ONE_Q30 : QW'(rot_cos[2]));
            r_f_c2 <= (rot_cos[3] < 0) ? '0 :
                      ((rot_cos[3] > ONE_CW) ? ONE_Q30 : QW'(rot_cos[3]));

            r_g_pa <= (2*QW)'(r_f_sa) * (2*QW)'(r_f_sa);
            r_g_pb <= (2*QW)'(r_f_sb) * (2*QW)'(r_f_sb);
            r_g_pc <= (2*QW)'(r_f_c1) * (2*QW)'(r_f_c2);

            r_h_a  <= QW'((r_g_pa + HALF_Q30) >> 30);
            r_h_b  <= QW'((r_g_pb + HALF_Q30) >> 30);
            r_h_cc <= QW'((r_g_pc + HALF_Q30) >> 30);

            r_i_prod <= (2*QW)'(r_h_cc) * (2*QW)'(r_h_b);
            r_i_a    <= r_h_a;

            r_j_h <= (h_sum > 32'(ONE_Q30)) ? ONE_Q30 : QW'(h_sum);
        end
    end

    //------------------------------------------------------------------
    // Square roots of h and 1 - h, both scaled to Q30
    //------------------------------------------------------------------
    logic            sq_valid;
    t_q30            sq_r, sq_q;
    logic [2*QW-1:0] rad_r, rad_q;

    assign rad_r = (2*QW)'(r_j_h) << 30;
    assign rad_q = (2*QW)'(ONE_Q30 - r_j_h) << 30;

    hvd_isqrt #(.RW(QW)) u_sqrt_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(r_j_valid),
        .i_rad(rad_r), .o_valid(sq_valid), .o_root(sq_r)
    );
    hvd_isqrt #(.RW(QW)) u_sqrt_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(r_j_valid),
        .i_rad(rad_q), .o_valid(), .o_root(sq_q)
    );

    //------------------------------------------------------------------
    // Half the central angle, atan2(sqrt(h), sqrt(1 - h)), by vectoring CORDIC
    //------------------------------------------------------------------
    logic vec_valid;
    t_cw  vec_angle;

    hvd_cordic_vec #(.STEPS(CORDIC_STEPS)) u_vec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(sq_valid),
        .i_x(CW'(sq_q)), .i_y(CW'(sq_r)), .o_valid(vec_valid), .o_angle(vec_angle)
    );

    //------------------------------------------------------------------
    // Stages K-M: clamp angle, scale by 2R, round to Q16, saturate
    //------------------------------------------------------------------
    localparam int LW = RADIUS_W + QW;

    logic              r_k_valid, r_l_valid, r_out_valid;
    t_q30              r_k_c;
    logic [LW-1:0]     r_l_prod;
    logic [DIST_W-1:0] r_out_dist;
    logic [LW-RADIUS_W:0] dist_rnd;

    assign dist_rnd = (LW - RADIUS_W + 1)'((r_l_prod + (LW'(1) << (RADIUS_W - 1))) >> RADIUS_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_valid   <= 1'b0;
            r_l_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_k_valid   <= vec_valid;
            r_l_valid   <= r_k_valid;
            r_out_valid <= r_l_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_k_c      <= (vec_angle < 0) ? '0 : QW'(vec_angle);
            r_l_prod   <= LW'(r_radius) * LW'(r_k_c);
            r_out_dist <= (dist_rnd > (LW - RADIUS_W + 1)'(DIST_MAX)) ? DIST_MAX
                                                                       : DIST_W'(dist_rnd);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_distance = r_out_dist;

`ifndef SYNTHESIS
    // an accepted transaction always lands in the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_a_valid)
        else $error("accepted transaction lost at entry");

    // a held output freezes the interior of the pipe
    a_hold_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(r_b_valid) && $stable(r_j_h) && $stable(r_k_c)))
        else $error("pipeline moved while output held");

    // haversine term never exceeds one
    a_h_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j_valid |-> (r_j_h <= ONE_Q30))
        else $error("haversine term above one");

    // a radius write takes effect on the next cycle
    a_radius_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && paddr[2] == REG_IDX_RADIUS) |=> (r_radius == $past(pwdata[RADIUS_W-1:0])))
        else $error("radius register not updated");
`endif

endmodule

`default_nettype wire
